[rtl/core/utf8_stream_validator_unit_assert.svh]
// Assertion macros for the UTF-8 stream validator.
`ifndef UTF8_STREAM_VALIDATOR_UNIT_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled in reset.
`define U8V_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("utf8v: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define U8V_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("utf8v: next-cycle check failed");

`else

`define U8V_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define U8V_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/core/utf8v_pkg.sv]
// Shared types and constants for the UTF-8 stream validator.
`default_nettype none

package utf8v_pkg;

  localparam int unsigned CP_W = 21;

  // Sequence length codes
  localparam logic [1:0] SEQ_NONE  = 2'd0;
  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

  localparam logic [CP_W-1:0] CP_FLOOR3    = 21'h000800;
  localparam logic [CP_W-1:0] CP_FLOOR4    = 21'h010000;
  localparam logic [CP_W-1:0] CP_LIMIT     = 21'h110000;
  localparam logic [CP_W-1:0] CP_NONCH_LO  = 21'h00FDD0;
  localparam logic [CP_W-1:0] CP_NONCH_HI  = 21'h00FDEF;
  localparam logic [CP_W-1:0] CP_SURR_BASE = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_MASK = 21'h1FF800;
  localparam logic [15:0]     CP_TAIL_FFFE = 16'hFFFE;

  typedef struct packed {
    logic            error_seen;
    logic [1:0]      cont_left;
    logic [1:0]      seq_len;
    logic [CP_W-1:0] code_point;
  } scan_state_t;

endpackage

`default_nettype wire

[rtl/core/utf8_stream_validator_unit.sv]
// Top level of the UTF-8 stream validator: input stage, decode step, result register.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one byte of a string per item in
//   in_data_byte, with in_last_byte high on the final byte. Strings follow one
//   another with no gap; an empty string is never sent.
//   Result channel (out_valid/out_ready) gives one item per string, on its
//   final byte: out_string_valid is 1 when the whole string is valid UTF-8.
//   Result path: a final byte is held in the input stage, then its verdict is
//   registered in the result register, which drives out_valid.
//   Throughput: one byte per cycle while no final byte waits for the result
//   register, set by the combinational decode step updating the scan state.
//   Reset (rst_n low, synchronous) empties both stages and clears the scan
//   state. When the receiver stalls, non-final bytes keep flowing; a final
//   byte waits in the input stage until the result register is free, and
//   in_ready drops meanwhile.
`default_nettype none

`include "utf8_stream_validator_unit_assert.svh"

module utf8_stream_validator_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_string_valid
);

  // input stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // scan state, advanced once per byte leaving the input stage
  utf8v_pkg::scan_state_t state_r, state_nxt, step_nxt;
  logic                   step_verdict;

  // result register
  logic out_valid_r, out_valid_nxt;
  logic out_verdict_r;

  logic in_fire, advance, out_fire, out_free;

  assign out_fire = out_valid_r && out_ready;
  assign out_free = !out_valid_r || out_ready;
  // a final byte needs room in the result register
  assign advance  = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  utf8v_step u_step (
    .cur       (state_r),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .nxt       (step_nxt),
    .verdict   (step_verdict)
  );

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    state_nxt     = advance ? step_nxt : state_r;
    out_valid_nxt = (advance && s1_last_r) ? 1'b1 : (out_fire ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (advance && s1_last_r) begin
      out_verdict_r <= step_verdict;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_string_valid = out_verdict_r;

  // scan state is cleared once a final byte has been judged
  `U8V_ASSERT_NXT(a_clear_after_last, clk, rst_n, advance && s1_last_r, state_r == '0)
  // an open sequence always has a length and no error recorded
  `U8V_ASSERT_IMP(a_open_seq, clk, rst_n, state_r.cont_left != 2'd0,
                  state_r.seq_len != utf8v_pkg::SEQ_NONE && !state_r.error_seen)
  // a final byte blocked by a full result register stalls the input
  `U8V_ASSERT_IMP(a_last_stall, clk, rst_n,
                  s1_valid_r && s1_last_r && out_valid_r && !out_ready, !in_ready)

endmodule

`default_nettype wire

[rtl/core/utf8v_cp_check.sv]
// Range checks on a decoded three- or four-byte code point.
`default_nettype none

module utf8v_cp_check (
  input  wire logic [utf8v_pkg::CP_W-1:0] cp,
  input  wire logic [1:0]                 seq_len,
  output logic                            cp_ok
);

  logic [utf8v_pkg::CP_W-1:0] floor_val;
  logic too_low, too_high, surrogate, nonchar_blk, tail_bad;

  always_comb begin
    floor_val   = (seq_len == utf8v_pkg::SEQ_THREE) ? utf8v_pkg::CP_FLOOR3
                                                    : utf8v_pkg::CP_FLOOR4;
    too_low     = cp < floor_val;
    too_high    = cp >= utf8v_pkg::CP_LIMIT;
    surrogate   = (cp & utf8v_pkg::CP_SURR_MASK) == utf8v_pkg::CP_SURR_BASE;
    nonchar_blk = (cp >= utf8v_pkg::CP_NONCH_LO) && (cp <= utf8v_pkg::CP_NONCH_HI);
    // low 16 bits FFFE or FFFF
    tail_bad    = (cp[15:0] & utf8v_pkg::CP_TAIL_FFFE) == utf8v_pkg::CP_TAIL_FFFE;
    cp_ok       = !(too_low || too_high || surrogate || nonchar_blk || tail_bad);
  end

endmodule

`default_nettype wire

[rtl/core/utf8v_step.sv]
// Per-byte decode step: next scan state and verdict for one item.
`default_nettype none

module utf8v_step (
  input  wire utf8v_pkg::scan_state_t cur,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   last_byte,
  output utf8v_pkg::scan_state_t      nxt,
  output logic                        verdict
);

  utf8v_pkg::scan_state_t     upd;
  logic [utf8v_pkg::CP_W-1:0] cp_shift;
  logic [1:0]                 cont_dec;
  logic                       cp_ok;

  assign cp_shift = {cur.code_point[utf8v_pkg::CP_W-7:0], data_byte[5:0]};
  assign cont_dec = cur.cont_left - 2'd1;

  utf8v_cp_check u_cp_check (
    .cp      (cp_shift),
    .seq_len (cur.seq_len),
    .cp_ok   (cp_ok)
  );

  always_comb begin
    upd = cur;
    if (!cur.error_seen) begin
      if (cur.cont_left != 2'd0) begin
        if (data_byte[7:6] != 2'b10) begin
          upd.error_seen = 1'b1;
          upd.cont_left  = 2'd0;
          upd.seq_len    = utf8v_pkg::SEQ_NONE;
        end else begin
          upd.code_point = cp_shift;
          upd.cont_left  = cont_dec;
          if (cont_dec == 2'd0) begin
            if (cur.seq_len >= utf8v_pkg::SEQ_THREE && !cp_ok) begin
              upd.error_seen = 1'b1;
            end
            upd.seq_len = utf8v_pkg::SEQ_NONE;
          end
        end
      end else if (data_byte[7] == 1'b0) begin
        // ASCII; NUL rejected
        if (data_byte == 8'h00) begin
          upd.error_seen = 1'b1;
        end
      end else if (data_byte[7:5] == 3'b110) begin
        if (data_byte[4:1] == 4'd0) begin
          upd.error_seen = 1'b1;
        end else begin
          upd.cont_left  = 2'd1;
          upd.seq_len    = utf8v_pkg::SEQ_TWO;
          upd.code_point = '0;
        end
      end else if (data_byte[7:4] == 4'b1110) begin
        upd.cont_left  = 2'd2;
        upd.seq_len    = utf8v_pkg::SEQ_THREE;
        upd.code_point = {{(utf8v_pkg::CP_W-4){1'b0}}, data_byte[3:0]};
      end else if (data_byte[7:3] == 5'b11110) begin
        upd.cont_left  = 2'd3;
        upd.seq_len    = utf8v_pkg::SEQ_FOUR;
        upd.code_point = {{(utf8v_pkg::CP_W-3){1'b0}}, data_byte[2:0]};
      end else begin
        upd.error_seen = 1'b1;
      end
    end

    verdict = !upd.error_seen && (upd.cont_left == 2'd0);
    nxt     = last_byte ? '0 : upd;
  end

endmodule

`default_nettype wire

[tb/sv/utf8_stream_validator_unit_test.sv]
// Self-checking testbench for the UTF-8 stream validator: directed and random strings.
`timescale 1ns / 1ps

module utf8_stream_validator_unit_test;

  // Watchdog: far beyond the slowest legal run (~2100 items, random stalls, one long hold)
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned EDGE_CP_COUNT = 22;

  typedef logic [utf8v_pkg::CP_W-1:0] cp_val_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_string_valid;

  utf8_stream_validator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_string_valid (out_string_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scan state of the predictor, mirrors the block's view of the current string
  logic            scan_error = 1'b0;
  logic [1:0]      scan_cont_left = 2'd0;
  logic [1:0]      scan_seq = utf8v_pkg::SEQ_NONE;
  cp_val_t         scan_cp = '0;

  // Verdicts still owed by the block, oldest first
  logic            verdict_q[$];
  logic            verdict_want;

  logic [7:0]      str_bytes[$];
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count = 0;
  int unsigned     bytes_sent = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     hold_token = 0;
  int unsigned     hold_seen = 0;
  int unsigned     hold_left = 0;

  // Legality of a decoded three- or four-byte code point
  function automatic logic cp_legal(input cp_val_t cp, input logic [1:0] seq);
    cp_val_t floor_cp;
    floor_cp = (seq == utf8v_pkg::SEQ_THREE) ? utf8v_pkg::CP_FLOOR3 : utf8v_pkg::CP_FLOOR4;
    if (cp < floor_cp) return 1'b0;
    if (cp >= utf8v_pkg::CP_LIMIT) return 1'b0;
    if ((cp & utf8v_pkg::CP_SURR_MASK) == utf8v_pkg::CP_SURR_BASE) return 1'b0;
    if (cp >= utf8v_pkg::CP_NONCH_LO && cp <= utf8v_pkg::CP_NONCH_HI) return 1'b0;
    if ((cp[15:0] & utf8v_pkg::CP_TAIL_FFFE) == utf8v_pkg::CP_TAIL_FFFE) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the predicted scan on one accepted item; queue the verdict on the final byte
  task automatic scan_byte(input logic [7:0] b, input logic last);
    if (!scan_error) begin
      if (scan_cont_left != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          // sequence broken by a non-continuation byte
          scan_error = 1'b1;
          scan_cont_left = 2'd0;
          scan_seq = utf8v_pkg::SEQ_NONE;
        end else begin
          scan_cp = {scan_cp[utf8v_pkg::CP_W-7:0], b[5:0]};
          scan_cont_left = scan_cont_left - 2'd1;
          if (scan_cont_left == 2'd0) begin
            if (scan_seq != utf8v_pkg::SEQ_TWO && !cp_legal(scan_cp, scan_seq))
              scan_error = 1'b1;
            scan_seq = utf8v_pkg::SEQ_NONE;
          end
        end
      end else if (b >= 8'h01 && b < 8'h80) begin
        // plain ASCII
      end else if (b[7:5] == 3'b110) begin
        if (b[4:1] == 4'd0) begin
          scan_error = 1'b1;  // C0/C1 lead
        end else begin
          scan_cont_left = 2'd1;
          scan_seq = utf8v_pkg::SEQ_TWO;
          scan_cp = '0;
        end
      end else if (b[7:4] == 4'b1110) begin
        scan_cont_left = 2'd2;
        scan_seq = utf8v_pkg::SEQ_THREE;
        scan_cp = cp_val_t'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        scan_cont_left = 2'd3;
        scan_seq = utf8v_pkg::SEQ_FOUR;
        scan_cp = cp_val_t'(b[2:0]);
      end else begin
        scan_error = 1'b1;  // NUL, stray continuation, F8..FF
      end
    end
    if (last) begin
      verdict_q.push_back(!scan_error && scan_cont_left == 2'd0);
      scan_error = 1'b0;
      scan_cont_left = 2'd0;
      scan_seq = utf8v_pkg::SEQ_NONE;
      scan_cp = '0;
    end
  endtask

  // Offer one item; valid only drops when an idle gap is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scan_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_bytes.size(); i++)
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
  endtask

  // Directed string of up to four bytes, packed first byte highest
  task automatic send_seq(input logic [31:0] packed_bytes, input int n);
    str_bytes.delete();
    for (int i = 0; i < n; i++)
      str_bytes.push_back(packed_bytes[31 - 8*i -: 8]);
    send_string();
  endtask

  task automatic push_cont();
    str_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  // Encode a code point as a three- or four-byte sequence (overlong if it fits in fewer)
  task automatic push_cp(input cp_val_t cp, input logic [1:0] seq);
    if (seq == utf8v_pkg::SEQ_THREE) begin
      str_bytes.push_back({4'b1110, cp[15:12]});
    end else begin
      str_bytes.push_back({5'b11110, cp[20:18]});
      str_bytes.push_back({2'b10, cp[17:12]});
    end
    str_bytes.push_back({2'b10, cp[11:6]});
    str_bytes.push_back({2'b10, cp[5:0]});
  endtask

  // Code points on either side of every range boundary the block checks
  function automatic cp_val_t edge_cp(input int unsigned idx);
    case (idx)
      0:  return 21'h000000;
      1:  return 21'h0007FF;
      2:  return 21'h000800;
      3:  return 21'h00D7FF;
      4:  return 21'h00D800;
      5:  return 21'h00DFFF;
      6:  return 21'h00E000;
      7:  return 21'h00FDCF;
      8:  return 21'h00FDD0;
      9:  return 21'h00FDEF;
      10: return 21'h00FDF0;
      11: return 21'h00FFFD;
      12: return 21'h00FFFE;
      13: return 21'h00FFFF;
      14: return 21'h010000;
      15: return 21'h01FFFE;
      16: return 21'h01FFFF;
      17: return 21'h10FFFD;
      18: return 21'h10FFFF;
      19: return 21'h110000;
      20: return 21'h1FFFFF;
      default: return 21'h0EFFFE;
    endcase
  endfunction

  // Mostly well-formed strings with random content; the rest broken or noisy
  task automatic build_random_string();
    int unsigned n_seg;
    int unsigned pick;
    logic        clean;
    cp_val_t     cp;
    str_bytes.delete();
    clean = ($urandom_range(99) < 55);
    n_seg = ($urandom_range(9) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 4);
    repeat (n_seg) begin
      pick = clean ? $urandom_range(71) : $urandom_range(99);
      if (pick < 30) begin
        str_bytes.push_back(8'($urandom_range(1, 127)));
      end else if (pick < 45) begin
        str_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        push_cont();
      end else if (pick < 60) begin
        cp = cp_val_t'($urandom_range(16'h0800, 16'hFFFF));
        push_cp(cp, utf8v_pkg::SEQ_THREE);
      end else if (pick < 72) begin
        cp = cp_val_t'($urandom_range(21'h010000, 21'h10FFFF));
        push_cp(cp, utf8v_pkg::SEQ_FOUR);
      end else if (pick < 86) begin
        cp = edge_cp($urandom_range(0, EDGE_CP_COUNT - 1));
        // short code points sometimes go out as overlong four-byte forms
        if (cp < utf8v_pkg::CP_FLOOR4 && $urandom_range(3) != 0)
          push_cp(cp, utf8v_pkg::SEQ_THREE);
        else
          push_cp(cp, utf8v_pkg::SEQ_FOUR);
      end else if (pick < 93) begin
        str_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 97) begin
        // lead interrupted by a plain byte
        str_bytes.push_back(8'($urandom_range(8'hE0, 8'hF7)));
        if ($urandom_range(1)) push_cont();
        str_bytes.push_back(8'($urandom_range(0, 127)));
      end else begin
        str_bytes.push_back(8'($urandom_range(8'hC0, 8'hC1)));
        push_cont();
      end
    end
    // sequence cut off by the end of the string
    if (!clean && $urandom_range(99) < 25) begin
      case ($urandom_range(2))
        0: str_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        1: begin
          str_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          repeat ($urandom_range(0, 1)) push_cont();
        end
        default: begin
          str_bytes.push_back(8'($urandom_range(8'hF0, 8'hF7)));
          repeat ($urandom_range(0, 2)) push_cont();
        end
      endcase
    end
  endtask

  task automatic run_random_strings(input int unsigned n_bytes);
    int unsigned stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      build_random_string();
      send_string();
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Each accepted result against the oldest owed verdict
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result item with nothing expected: expected none, actual %0b",
                 $time, out_string_valid);
        mismatch_count++;
      end else begin
        verdict_want = verdict_q.pop_front();
        if (out_string_valid !== verdict_want) begin
          $display("%0t: string_valid mismatch: expected %0b, actual %0b",
                   $time, verdict_want, out_string_valid);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
               $time, cycle_count, verdict_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Boundary bytes and one string per rule, each string on its own
  task automatic test_directed_rules();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_seq(32'h7F000000, 1);  // lone ASCII, top value
    send_seq(32'h00000000, 1);  // NUL
    send_seq(32'hC0800000, 2);  // C0 lead
    send_seq(32'hC2800000, 2);  // lowest legal two-byte lead
    send_seq(32'hE0A08000, 3);  // U+0800
    send_seq(32'hEDA08000, 3);  // surrogate
    send_seq(32'hEFBFBF00, 3);  // U+FFFF
    send_seq(32'hF4908080, 4);  // above U+10FFFF
    send_seq(32'h80410000, 2);  // error mid-string, later byte ignored
    send_seq(32'hF09F9800, 3);  // cut off
  endtask

  task automatic test_random_no_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_strings(450);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 48;
    recv_stall_pct = 0;
    run_random_strings(450);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    recv_stall_pct = 48;
    run_random_strings(450);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 38;
    recv_stall_pct = 38;
    run_random_strings(450);
  endtask

  // Receiver holds off while the sender keeps offering: final bytes back up the input
  task automatic test_backpressure_fill();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_token++;
    run_random_strings(150);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_rules();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_backpressure_fill();

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/utf8v_pkg.sv
rtl/core/utf8v_cp_check.sv
rtl/core/utf8v_step.sv
rtl/core/utf8_stream_validator_unit.sv
tb/sv/utf8_stream_validator_unit_test.sv
